>>> sv/iaf_pkg.sv
`timescale 1ns / 1ps

package iaf_pkg;

    // Width of the multiplier accumulator: a 33-bit by 25-bit product plus
    // headroom for the three-term down-axis sum.
    localparam int ACC_W = 60;

    localparam int MB_W = 25;

    localparam logic [23:0] BARO_WEIGHT_RST  = 24'd32768;
    localparam logic [23:0] ACCEL_WEIGHT_RST = 24'd1310720;
    localparam logic [23:0] BIAS_WEIGHT_RST  = 24'd3277;

    localparam logic [1:0] REG_BARO_WEIGHT  = 2'd0;
    localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd1;
    localparam logic [1:0] REG_BIAS_WEIGHT  = 2'd2;

    typedef struct packed {
        logic               ready_req;
        logic [15:0]        step_time;
        logic               baro_new;
        logic signed [31:0] baro_altitude;
        logic               accel_new;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [15:0] rot_down_x;
        logic signed [15:0] rot_down_y;
        logic signed [15:0] rot_down_z;
    } iaf_in_t;

    typedef struct packed {
        logic signed [31:0] altitude_est;
        logic signed [31:0] velocity_est;
        logic signed [31:0] accel_est;
    } iaf_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] value;
    } iaf_cfg_t;

    typedef enum logic [1:0] {
        K_ALU = 2'd0,
        K_MUL = 2'd1,
        K_MAC = 2'd2,
        K_DIV = 2'd3
    } kind_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (x > hi)
            return 32'h7FFF_FFFF;
        else if (x < lo)
            return 32'h8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sx32(input logic signed [31:0] x);
        return ACC_W'(x);
    endfunction

endpackage

>>> sv/iaf_if.sv
`timescale 1ns / 1ps

interface iaf_sample_if;
    import iaf_pkg::*;
    logic    valid;
    logic    ready;
    iaf_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iaf_result_if;
    import iaf_pkg::*;
    logic     valid;
    logic     ready;
    iaf_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iaf_cfg_if;
    import iaf_pkg::*;
    logic     valid;
    logic     ready;
    iaf_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/inertial_altitude_filter.sv
`timescale 1ns / 1ps

// Complementary inertial altitude filter for the vertical axis. Each sample
// word carries a tick time and optionally a fresh barometer altitude and a
// fresh body acceleration with the down row of the rotation matrix; the block
// answers every sample word with one result word holding altitude, vertical
// velocity and vertical acceleration in signed fixed point, saturated to 32
// bits. A sample word with ready_req low returns the current estimates
// unchanged. An update runs 27 micro-steps on one shared bit-serial
// multiplier that retires one multiplier bit per cycle and a bit-serial
// divide by three, each step passing through an issue and a write-back
// state. With a fresh acceleration sample there are 23 products; without
// one the three down-axis products are skipped. The block accepts one
// sample word at a time; a result word waiting on the output does not
// block acceptance of the next sample, but holds that sample's result in
// S_DONE until the output word is taken.
// The configuration channel is always ready and should only be written while
// no sample is in flight.
module inertial_altitude_filter
    import iaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    iaf_sample_if.sink          sample,
    iaf_result_if.source        result,
    iaf_cfg_if.sink             cfg
);

    localparam logic [4:0] SH_F   = 5'(FRAC_BITS);
    localparam logic [4:0] SH_ROT = 5'd14;
    localparam logic [4:0] SH_DT  = 5'd16;
    localparam logic [4:0] SH_DT2 = 5'd17;
    localparam logic [5:0] MUL_LAST = 6'(MB_W - 1);
    localparam logic [5:0] DIV_LAST = 6'd32;
    localparam logic [4:0] PC_LAST  = 5'd26;
    localparam longint GRAV_L =
        (64'd980665 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic signed [ACC_W-1:0] GRAV = ACC_W'(GRAV_L);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WB    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] pc_reg;

    // Configuration.
    logic [23:0] wb_reg, wa_reg, bw_reg;

    // Filter state.
    logic signed [31:0] pos_reg, vel_reg, acc_reg;
    logic signed [31:0] bias_reg [3];
    logic signed [31:0] berr_reg, aerr_reg;
    logic signed [15:0] rot_reg [3];

    // Latched sample word and working values.
    iaf_in_t            in_reg;
    logic signed [31:0] t_reg, corr_reg, vdt_reg, adt_reg;

    // Bit-serial multiplier and divider.
    logic signed [ACC_W-1:0] macc_reg, ma_reg;
    logic [MB_W-1:0]         mb_reg;
    logic [5:0]              cnt_reg;
    logic [32:0]             dq_reg;
    logic [1:0]              rem_reg;
    logic                    dsign_reg;

    // Output register.
    logic     out_valid_reg;
    iaf_out_t out_reg;

    logic signed [32:0]   op_a;
    logic [MB_W-1:0]      op_b;
    logic [4:0]           op_sh;
    kind_t                op_kind;
    logic signed [ACC_W-1:0] half_s, rnd_s;
    logic signed [31:0]   prod;
    logic signed [ACC_W-1:0] addend;
    logic [2:0]           r3;
    logic signed [ACC_W-1:0] quot;
    logic [32:0]          dmag;
    logic                 accept;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    function automatic logic [MB_W-1:0] b_w(input logic [23:0] w);
        return MB_W'(w);
    endfunction

    function automatic logic [MB_W-1:0] b_rot(input logic signed [15:0] r);
        return MB_W'(r);
    endfunction

    // Operand selection for each micro-step of the update.
    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        op_sh   = SH_F;
        op_kind = K_ALU;
        case (pc_reg)
            5'd1:
            begin
                op_a    = 33'(in_reg.accel_x) - 33'(bias_reg[0]);
                op_b    = b_rot(in_reg.rot_down_x);
                op_kind = in_reg.accel_new ? K_MUL : K_ALU;
            end
            5'd2:
            begin
                op_a    = 33'(in_reg.accel_y) - 33'(bias_reg[1]);
                op_b    = b_rot(in_reg.rot_down_y);
                op_kind = in_reg.accel_new ? K_MAC : K_ALU;
            end
            5'd3:
            begin
                op_a    = 33'(in_reg.accel_z) - 33'(bias_reg[2]);
                op_b    = b_rot(in_reg.rot_down_z);
                op_kind = in_reg.accel_new ? K_MAC : K_ALU;
            end
            5'd4:  op_sh = SH_ROT;
            5'd5:  begin op_a = 33'(berr_reg); op_b = b_w(wb_reg); op_kind = K_MUL; end
            5'd6:  begin op_a = 33'(t_reg); op_b = b_w(wb_reg); op_kind = K_MUL; end
            5'd8:
            begin
                op_a = 33'(corr_reg); op_b = b_rot(rot_reg[0]); op_sh = SH_ROT;
                op_kind = K_MUL;
            end
            5'd11:
            begin
                op_a = 33'(corr_reg); op_b = b_rot(rot_reg[1]); op_sh = SH_ROT;
                op_kind = K_MUL;
            end
            5'd14:
            begin
                op_a = 33'(corr_reg); op_b = b_rot(rot_reg[2]); op_sh = SH_ROT;
                op_kind = K_MUL;
            end
            5'd9, 5'd12, 5'd15:
            begin
                op_a = 33'(t_reg); op_b = b_w(bw_reg); op_kind = K_MUL;
            end
            5'd10, 5'd13, 5'd16, 5'd21, 5'd26:
            begin
                op_a = 33'(t_reg); op_b = MB_W'(in_reg.step_time); op_sh = SH_DT;
                op_kind = K_MUL;
            end
            5'd17:
            begin
                op_a = 33'(vel_reg); op_b = MB_W'(in_reg.step_time); op_sh = SH_DT;
                op_kind = K_MUL;
            end
            5'd18:
            begin
                op_a = 33'(acc_reg); op_b = MB_W'(in_reg.step_time); op_sh = SH_DT;
                op_kind = K_MUL;
            end
            5'd19:
            begin
                op_a = 33'(adt_reg); op_b = MB_W'(in_reg.step_time); op_sh = SH_DT2;
                op_kind = K_MUL;
            end
            5'd20: begin op_a = 33'(berr_reg); op_b = b_w(wb_reg); op_kind = K_MUL; end
            5'd22, 5'd23:
            begin
                op_a = 33'(t_reg); op_b = b_w(wb_reg); op_kind = K_MUL;
            end
            5'd24: op_kind = K_DIV;
            5'd25: begin op_a = 33'(aerr_reg); op_b = b_w(wa_reg); op_kind = K_MUL; end
            default: op_kind = K_ALU;
        endcase
    end

    // Round half up and saturate the accumulated product.
    always_comb
    begin
        half_s = ACC_W'(1) <<< (op_sh - 5'd1);
        rnd_s  = (macc_reg + half_s) >>> op_sh;
        prod   = sat32(rnd_s);
    end

    always_comb
    begin
        if (mb_reg[0])
            addend = (cnt_reg == MUL_LAST) ? -ma_reg : ma_reg;
        else
            addend = '0;
        r3   = {rem_reg, dq_reg[32]};
        quot = dsign_reg ? -ACC_W'(dq_reg) : ACC_W'(dq_reg);
        dmag = t_reg[31] ? -33'(t_reg) : 33'(t_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = sample.data.ready_req ? S_ISSUE : S_DONE;
            S_ISSUE:
                case (op_kind)
                    K_MUL, K_MAC: state_next = S_MUL;
                    K_DIV:        state_next = S_DIV;
                    default:      state_next = S_WB;
                endcase
            S_MUL:
                if (cnt_reg == MUL_LAST)
                    state_next = S_WB;
            S_DIV:
                if (cnt_reg == DIV_LAST)
                    state_next = S_WB;
            S_WB:
                state_next = (pc_reg == PC_LAST) ? S_DONE : S_ISSUE;
            S_DONE:
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            wb_reg        <= BARO_WEIGHT_RST;
            wa_reg        <= ACCEL_WEIGHT_RST;
            bw_reg        <= BIAS_WEIGHT_RST;
            pos_reg       <= '0;
            vel_reg       <= '0;
            acc_reg       <= '0;
            berr_reg      <= '0;
            aerr_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i] <= '0;
                rot_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.data.index)
                    REG_BARO_WEIGHT:  wb_reg <= cfg.data.value;
                    REG_ACCEL_WEIGHT: wa_reg <= cfg.data.value;
                    REG_BIAS_WEIGHT:  bw_reg <= cfg.data.value;
                    default: ;
                endcase
            end

            // A finished update, or a sample with ready_req low, loads the output once the previous word is gone.
            if (state_reg == S_DONE && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                    pc_reg <= '0;
                S_WB:
                begin
                    pc_reg <= pc_reg + 5'd1;
                    case (pc_reg)
                        5'd0:
                            if (in_reg.baro_new)
                                berr_reg <= sat32(-sx32(in_reg.baro_altitude) - sx32(pos_reg));
                        5'd4:
                            if (in_reg.accel_new)
                            begin
                                aerr_reg   <= sat32(sx32(prod) + GRAV - sx32(acc_reg));
                                rot_reg[0] <= in_reg.rot_down_x;
                                rot_reg[1] <= in_reg.rot_down_y;
                                rot_reg[2] <= in_reg.rot_down_z;
                            end
                        5'd7:  corr_reg <= sat32(-sx32(t_reg));
                        5'd10: bias_reg[0] <= sat32(sx32(bias_reg[0]) + sx32(prod));
                        5'd13: bias_reg[1] <= sat32(sx32(bias_reg[1]) + sx32(prod));
                        5'd16: bias_reg[2] <= sat32(sx32(bias_reg[2]) + sx32(prod));
                        5'd17: vdt_reg <= prod;
                        5'd18: adt_reg <= prod;
                        5'd19:
                        begin
                            pos_reg <= sat32(sx32(sat32(sx32(pos_reg) + sx32(vdt_reg)))
                                             + sx32(prod));
                            vel_reg <= sat32(sx32(vel_reg) + sx32(adt_reg));
                        end
                        5'd21:
                        begin
                            t_reg   <= prod;
                            pos_reg <= sat32(sx32(pos_reg) + sx32(prod));
                        end
                        5'd22:
                        begin
                            t_reg   <= prod;
                            vel_reg <= sat32(sx32(vel_reg) + sx32(prod));
                        end
                        5'd24: acc_reg <= sat32(sx32(acc_reg) + quot);
                        5'd26: acc_reg <= sat32(sx32(acc_reg) + sx32(prod));
                        5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
                        5'd20, 5'd23, 5'd25:
                            t_reg <= prod;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Payload registers: sample latch, serial units and the result word.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= sample.data;

        case (state_reg)
            S_ISSUE:
            begin
                cnt_reg <= '0;
                ma_reg  <= ACC_W'(op_a);
                mb_reg  <= op_b;
                // Only a fresh product clears the accumulator, so the down-axis
                // sum survives until its rounding step reads it.
                if (op_kind == K_MUL)
                    macc_reg <= '0;
                dq_reg    <= dmag + 33'd1;
                rem_reg   <= '0;
                dsign_reg <= t_reg[31];
            end
            S_MUL:
            begin
                macc_reg <= macc_reg + addend;
                ma_reg   <= ma_reg <<< 1;
                mb_reg   <= mb_reg >> 1;
                cnt_reg  <= cnt_reg + 6'd1;
            end
            S_DIV:
            begin
                if (r3 >= 3'd3)
                begin
                    rem_reg <= 2'(r3 - 3'd3);
                    dq_reg  <= {dq_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r3[1:0];
                    dq_reg  <= {dq_reg[31:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_DONE:
                if (!out_valid_reg || result.ready)
                begin
                    out_reg.altitude_est <= pos_reg;
                    out_reg.velocity_est <= vel_reg;
                    out_reg.accel_est    <= acc_reg;
                end
            default: ;
        endcase
    end

endmodule
